>>> rtl/ffha_pkg.sv
package ffha_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned HEAP_BYTES_DEF      = 65536;
  localparam int unsigned ALIGN_BYTES_DEF     = 8;
  localparam int unsigned HEADER_BYTES_DEF    = 24;
  localparam int unsigned MAX_FREE_BLOCKS_DEF = 64;

  // Offsets and sizes wrap modulo 2^32 inside the block
  localparam int unsigned DATA_W = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
  } entry_t;

endpackage

>>> rtl/ffha_ram.sv
module ffha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/first_fit_heap_allocator.sv
// First-fit heap allocator, address-ordered free table with coalescing.
// An alloc scans the table entry by entry, then splits the fit or removes it and moves later
// entries down; a free reads the block size, scans, checks both neighbours, and inserts an
// isolated block after moving later entries up. The table has one read port.
// One command at a time. Reset: one free block spans the heap; no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES      = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES     = ffha_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned HEADER_BYTES    = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_FREE_BLOCKS = ffha_pkg::MAX_FREE_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [16:0] req_bytes_i,
  input  logic [15:0] addr_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_addr_o
);

  localparam int unsigned DW          = ffha_pkg::DATA_W;
  localparam int unsigned STORE_DEPTH = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned SAW         = $clog2(STORE_DEPTH);
  localparam int unsigned IDX_W       = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned CNT_W       = $clog2(MAX_FREE_BLOCKS + 1);
  localparam logic [DW-1:0]    HDR    = DW'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAXCNT = CNT_W'(MAX_FREE_BLOCKS);
  localparam ffha_pkg::entry_t RESET_ENT = '{start: '0, size: DW'(HEAP_BYTES - HEADER_BYTES)};

  typedef enum logic [3:0] {
    S_IDLE, S_FREE_SZ, S_SCAN, S_ALLOC_ACT, S_EVAL1, S_EVAL2, S_SHDN, S_SHUP, S_INS_WR
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               e0init_q, e0init_d;     // entry 0 still holds its reset value
  logic               rd0_q, rd0_d;           // pending read hit entry 0 while e0init
  logic [CNT_W-1:0]   ri_q, ri_d, di_q, di_d, p_q, p_d, sk_q, sk_d;
  logic               dv_q, dv_d;
  logic               cmd_q, cmd_d;
  logic [DW-1:0]      need_q, need_d, hdr_q, hdr_d, size_q, size_d;
  logic [DW-1:0]      pend_q, pend_d, hend_q, hend_d, lsum_q, lsum_d, rsum_q, rsum_d;
  ffha_pkg::entry_t   prev_q, prev_d, cur_q, cur_d;
  logic               valid_q, valid_d;
  logic [1:0]         status_q, status_d;
  logic [15:0]        paddr_q, paddr_d;

  // table RAM ports
  logic               t_we, t_re;
  logic [IDX_W-1:0]   t_waddr, t_raddr;
  ffha_pkg::entry_t   t_wdata, t_rdata, ent;
  // block size store ports
  logic               s_we, s_re;
  logic [SAW-1:0]     s_waddr, s_raddr;
  logic [DW-1:0]      s_wdata, s_rdata;

  logic [DW-1:0]      req_ext, need_calc, hdr_in, rem;
  logic               hit, scan_end, left, right;

  ffha_ram #(.WIDTH($bits(ffha_pkg::entry_t)), .DEPTH(MAX_FREE_BLOCKS)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  ffha_ram #(.WIDTH(DW), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign ent = rd0_q ? RESET_ENT : t_rdata;

  // zero-byte request counts as one; round up to the alignment
  assign req_ext   = (req_bytes_i == '0) ? DW'(1) : DW'(req_bytes_i);
  assign need_calc = ((req_ext + DW'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES;
  assign hdr_in    = DW'(addr_i) - HDR;
  assign rem       = cur_q.size - need_q;

  assign hit = (cmd_q == ffha_pkg::CMD_ALLOC) ? (ent.size >= need_q) : (ent.start > hdr_q);
  assign scan_end = (!dv_q && ri_q == cnt_q) || (dv_q && !hit && (di_q + 1'b1) == cnt_q);

  assign left  = (p_q != '0) && (pend_q == hdr_q);
  assign right = (p_q < cnt_q) && (hend_q == cur_q.start);

  always_comb begin
    state_d  = state_q;  cnt_d  = cnt_q;  e0init_d = e0init_q;
    ri_d     = ri_q;     di_d   = di_q;   p_d      = p_q;     sk_d = sk_q;
    dv_d     = 1'b0;     cmd_d  = cmd_q;
    need_d   = need_q;   hdr_d  = hdr_q;  size_d   = size_q;
    pend_d   = pend_q;   hend_d = hend_q; lsum_d   = lsum_q;  rsum_d = rsum_q;
    prev_d   = prev_q;   cur_d  = cur_q;
    valid_d  = 1'b0;     status_d = status_q; paddr_d = paddr_q;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_re = 1'b0; t_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          paddr_d = '0;
          ri_d    = '0;
          if (cmd_i == ffha_pkg::CMD_ALLOC) begin
            need_d  = need_calc;
            state_d = S_SCAN;
          end else begin
            hdr_d   = hdr_in;
            s_re    = 1'b1;
            s_raddr = SAW'((hdr_in / ALIGN_BYTES) % STORE_DEPTH);
            state_d = S_FREE_SZ;
          end
        end
      end
      S_FREE_SZ: begin
        size_d  = s_rdata;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // one read issued per cycle, data compared the cycle after
        if (ri_q < cnt_q) begin
          t_re    = 1'b1;
          t_raddr = ri_q[IDX_W-1:0];
          ri_d    = ri_q + 1'b1;
          di_d    = ri_q;
          dv_d    = 1'b1;
        end
        if (dv_q && hit) begin
          p_d     = di_q;
          cur_d   = ent;
          dv_d    = 1'b0;
          state_d = (cmd_q == ffha_pkg::CMD_ALLOC) ? S_ALLOC_ACT : S_EVAL1;
        end else if (scan_end) begin
          dv_d = 1'b0;
          if (cmd_q == ffha_pkg::CMD_ALLOC) begin
            valid_d  = 1'b1;
            status_d = ffha_pkg::ST_NOFIT;
            state_d  = S_IDLE;
          end else begin
            p_d = cnt_q;
            if (dv_q) prev_d = ent;
            state_d = S_EVAL1;
          end
        end else if (dv_q) begin
          prev_d = ent;
        end
      end
      S_ALLOC_ACT: begin
        paddr_d = 16'(cur_q.start + HDR);
        s_we    = 1'b1;
        s_waddr = SAW'((cur_q.start / ALIGN_BYTES) % STORE_DEPTH);
        if (rem > HDR) begin
          // split: remainder keeps the slot
          s_wdata       = need_q;
          t_we          = 1'b1;
          t_waddr       = p_q[IDX_W-1:0];
          t_wdata.start = cur_q.start + HDR + need_q;
          t_wdata.size  = rem - HDR;
          if (p_q == '0) e0init_d = 1'b0;
          valid_d  = 1'b1;
          status_d = ffha_pkg::ST_OK;
          state_d  = S_IDLE;
        end else begin
          s_wdata = cur_q.size;
          cnt_d   = cnt_q - 1'b1;
          if ((p_q + 1'b1) < cnt_q) begin
            t_re    = 1'b1;
            t_raddr = IDX_W'(p_q + 1'b1);
            sk_d    = p_q;
            state_d = S_SHDN;
          end else begin
            valid_d  = 1'b1;
            status_d = ffha_pkg::ST_OK;
            state_d  = S_IDLE;
          end
        end
      end
      S_EVAL1: begin
        pend_d  = prev_q.start + HDR + prev_q.size;
        hend_d  = hdr_q + HDR + size_q;
        lsum_d  = prev_q.size + HDR + size_q;
        rsum_d  = size_q + HDR + cur_q.size;
        state_d = S_EVAL2;
      end
      S_EVAL2: begin
        valid_d  = 1'b1;
        status_d = ffha_pkg::ST_OK;
        state_d  = S_IDLE;
        if (left) begin
          t_we          = 1'b1;
          t_waddr       = IDX_W'(p_q - 1'b1);
          t_wdata.start = prev_q.start;
          t_wdata.size  = right ? (lsum_q + HDR + cur_q.size) : lsum_q;
          if (p_q == CNT_W'(1)) e0init_d = 1'b0;
          if (right) begin
            // merged both sides: drop the right neighbour
            cnt_d = cnt_q - 1'b1;
            if ((p_q + 1'b1) < cnt_q) begin
              t_re     = 1'b1;
              t_raddr  = IDX_W'(p_q + 1'b1);
              sk_d     = p_q;
              valid_d  = 1'b0;
              state_d  = S_SHDN;
            end
          end
        end else if (right) begin
          t_we          = 1'b1;
          t_waddr       = p_q[IDX_W-1:0];
          t_wdata.start = hdr_q;
          t_wdata.size  = rsum_q;
          if (p_q == '0) e0init_d = 1'b0;
        end else if (cnt_q >= MAXCNT) begin
          status_d = ffha_pkg::ST_FULL;
        end else begin
          valid_d = 1'b0;
          cnt_d   = cnt_q + 1'b1;
          if (cnt_q > p_q) begin
            t_re    = 1'b1;
            t_raddr = IDX_W'(cnt_q - 1'b1);
            sk_d    = cnt_q;
            state_d = S_SHUP;
          end else begin
            state_d = S_INS_WR;
          end
        end
      end
      S_SHDN: begin
        // move entry sk+1 down to sk; cnt already reduced
        t_we    = 1'b1;
        t_waddr = sk_q[IDX_W-1:0];
        t_wdata = ent;
        if (sk_q == '0) e0init_d = 1'b0;
        if ((sk_q + 1'b1) < cnt_q) begin
          t_re    = 1'b1;
          t_raddr = IDX_W'(sk_q + 2'd2);
          sk_d    = sk_q + 1'b1;
        end else begin
          valid_d  = 1'b1;
          status_d = ffha_pkg::ST_OK;
          state_d  = S_IDLE;
        end
      end
      S_SHUP: begin
        // move entry sk-1 up to sk
        t_we    = 1'b1;
        t_waddr = sk_q[IDX_W-1:0];
        t_wdata = ent;
        if ((sk_q - 1'b1) > p_q) begin
          t_re    = 1'b1;
          t_raddr = IDX_W'(sk_q - 2'd2);
          sk_d    = sk_q - 1'b1;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        t_we          = 1'b1;
        t_waddr       = p_q[IDX_W-1:0];
        t_wdata.start = hdr_q;
        t_wdata.size  = size_q;
        if (p_q == '0) e0init_d = 1'b0;
        valid_d  = 1'b1;
        status_d = ffha_pkg::ST_OK;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    rd0_d = t_re && (t_raddr == '0) && e0init_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= CNT_W'(1);
      e0init_q <= 1'b1;
      rd0_q    <= 1'b0;
      dv_q     <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      e0init_q <= e0init_d;
      rd0_q    <= rd0_d;
      dv_q     <= dv_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q     <= ri_d;     di_q   <= di_d;   p_q    <= p_d;    sk_q <= sk_d;
    cmd_q    <= cmd_d;    need_q <= need_d; hdr_q  <= hdr_d;  size_q <= size_d;
    pend_q   <= pend_d;   hend_q <= hend_d; lsum_q <= lsum_d; rsum_q <= rsum_d;
    prev_q   <= prev_d;   cur_q  <= cur_d;
    status_q <= status_d; paddr_q <= paddr_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign payload_addr_o = paddr_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned HEAP  = ffha_pkg::HEAP_BYTES_DEF;
  localparam int unsigned ALIGN = ffha_pkg::ALIGN_BYTES_DEF;
  localparam int unsigned HDR   = ffha_pkg::HEADER_BYTES_DEF;
  localparam int unsigned MAXF  = ffha_pkg::MAX_FREE_BLOCKS_DEF;
  localparam int unsigned DEPTH = HEAP / ALIGN;
  // timeout bound, many times over what the run needs
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        cmd_i = ffha_pkg::CMD_ALLOC;
  logic [16:0] req_bytes_i = '0;
  logic [15:0] addr_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic [1:0]  status_o;
  logic [15:0] payload_addr_o;

  first_fit_heap_allocator i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .req_bytes_i, .addr_i,
    .valid_o, .status_o, .payload_addr_o
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] paddr;
  } result_t;

  // expected answers, oldest first
  result_t answer_q[$];

  // mirror of the free table and the per-block size store
  int unsigned free_hdr[MAXF];
  int unsigned free_bytes[MAXF];
  int unsigned free_entries = 1;
  int unsigned size_mem[DEPTH];
  bit          size_known[DEPTH];

  // payload offsets currently handed out
  logic [15:0] granted_q[$];

  int     errors, n_checked, n_alloc, n_free, n_nofit, n_full;
  longint cycles;
  bit     no_idle;

  initial begin
    free_hdr[0]   = 0;
    free_bytes[0] = HEAP - HDR;
  end

  function automatic int unsigned slot_of(int unsigned hdr);
    return (hdr / ALIGN) % DEPTH;
  endfunction

  function automatic void drop_free(int unsigned i);
    for (int unsigned k = i; k + 1 < free_entries; k++) begin
      free_hdr[k]   = free_hdr[k + 1];
      free_bytes[k] = free_bytes[k + 1];
    end
    free_entries--;
  endfunction

  function automatic result_t predict_alloc(logic [16:0] req);
    longint unsigned r, need, sz;
    int unsigned i, hdr, avail, want;
    result_t res;
    res = '0;
    r = 64'(req);
    if (r == 0) r = 1;  // zero bytes counts as one
    need = ((r + ALIGN - 1) / ALIGN) * ALIGN;
    for (i = 0; i < free_entries; i++) begin
      sz = 64'(free_bytes[i]);
      if (sz >= need) break;
    end
    if (i >= free_entries) begin
      res.status = ffha_pkg::ST_NOFIT;
      return res;
    end
    want  = 32'(need);
    hdr   = free_hdr[i];
    avail = free_bytes[i];
    if (avail - want > HDR) begin
      // split: remainder keeps the slot
      free_hdr[i]   = hdr + HDR + want;
      free_bytes[i] = avail - want - HDR;
      size_mem[slot_of(hdr)] = want;
    end else begin
      drop_free(i);
      size_mem[slot_of(hdr)] = avail;
    end
    size_known[slot_of(hdr)] = 1'b1;
    res.status = ffha_pkg::ST_OK;
    res.paddr  = 16'(hdr + HDR);
    return res;
  endfunction

  function automatic result_t predict_free(logic [15:0] a);
    int unsigned hdr, sz, p;
    bit left, right;
    result_t res;
    res = '0;
    hdr = 32'(a) - HDR;  // wraps below the first header
    sz  = size_mem[slot_of(hdr)];
    for (p = 0; p < free_entries; p++)
      if (free_hdr[p] > hdr) break;
    left  = p > 0 && free_hdr[p-1] + HDR + free_bytes[p-1] == hdr;
    right = p < free_entries && hdr + HDR + sz == free_hdr[p];
    if (left && right) begin
      free_bytes[p-1] += HDR + sz + HDR + free_bytes[p];
      drop_free(p);
    end else if (left) begin
      free_bytes[p-1] += HDR + sz;
    end else if (right) begin
      free_bytes[p] = sz + HDR + free_bytes[p];
      free_hdr[p]   = hdr;
    end else begin
      if (free_entries >= MAXF) begin
        res.status = ffha_pkg::ST_FULL;  // block stays granted
        return res;
      end
      for (int unsigned k = free_entries; k > p; k--) begin
        free_hdr[k]   = free_hdr[k-1];
        free_bytes[k] = free_bytes[k-1];
      end
      free_hdr[p]   = hdr;
      free_bytes[p] = sz;
      free_entries++;
    end
    res.status = ffha_pkg::ST_OK;
    return res;
  endfunction

  function automatic bit freeable(logic [15:0] a);
    return size_known[slot_of(32'(a) - HDR)];
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // One command transfer. Called at a rising edge; returns at the accepting edge
  // with start still high, so the next call can follow without a drop.
  task automatic issue(input logic c, input logic [16:0] rb, input logic [15:0] ad,
                       output result_t res);
    if (!no_idle && $urandom_range(99) < 12) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    cmd_i       <= c;
    req_bytes_i <= rb;
    addr_i      <= ad;
    do @(posedge clk_i); while (busy_o);
    res = (c == ffha_pkg::CMD_FREE) ? predict_free(ad) : predict_alloc(rb);
    answer_q.push_back(res);
    if (c == ffha_pkg::CMD_FREE) n_free++; else n_alloc++;
    if (res.status == ffha_pkg::ST_NOFIT) n_nofit++;
    if (res.status == ffha_pkg::ST_FULL) n_full++;
  endtask

  task automatic alloc_bytes(input logic [16:0] rb, output result_t res);
    issue(ffha_pkg::CMD_ALLOC, rb, 16'($urandom), res);
    if (res.status == ffha_pkg::ST_OK) granted_q.push_back(res.paddr);
  endtask

  task automatic free_at(input logic [15:0] ad);
    result_t res;
    int idx[$];
    issue(ffha_pkg::CMD_FREE, 17'($urandom), ad, res);
    if (res.status == ffha_pkg::ST_OK) begin
      idx = granted_q.find_first_index(x) with (x == ad);
      if (idx.size() != 0) granted_q.delete(idx[0]);
    end
  endtask

  task automatic free_all_granted();
    int guard;
    guard = 0;
    while (granted_q.size() != 0 && guard < 1000) begin
      free_at(granted_q[$urandom_range(granted_q.size() - 1)]);
      guard++;
    end
  endtask

  // Field extremes, zero and oversized requests, every merge shape,
  // insertion in front of the table head.
  task automatic test_edges();
    result_t r;
    logic [15:0] a, b, c;
    alloc_bytes(17'd65536, r);  // as large as the whole heap
    alloc_bytes(17'd65535, r);
    alloc_bytes(17'd0, r);      // treated as one byte
    alloc_bytes(17'd8, r);
    alloc_bytes(17'd40, r);
    free_all_granted();
    alloc_bytes(17'd1, r);   a = r.paddr;
    alloc_bytes(17'd100, r); b = r.paddr;
    alloc_bytes(17'd9, r);   c = r.paddr;
    free_at(a);  // new head, isolated
    free_at(b);  // merges left only
    free_at(c);  // merges on both sides
    alloc_bytes(17'd16, r);  a = r.paddr;
    alloc_bytes(17'd32, r);  b = r.paddr;
    free_at(b);  // merges right into the remainder
    free_at(a);
  endtask

  // Whole-heap grant empties the table; then nothing fits.
  task automatic test_exhaust();
    result_t r;
    alloc_bytes(17'(HEAP - HDR - 12), r);  // leftover too small to split
    alloc_bytes(17'd1, r);
    // the failed answer gives offset zero, whose size entry was never written
    granted_q.delete();
    granted_q.push_back(16'(HDR));
    free_all_granted();
  endtask

  // Isolated frees until the table overflows.
  task automatic test_table_full();
    result_t r;
    logic [15:0] blocks[$];
    for (int i = 0; i < 130; i++) begin
      alloc_bytes(17'($urandom_range(1, 16)), r);
      blocks.push_back(r.paddr);
    end
    for (int i = 0; i < 130; i += 2) begin
      if (freeable(blocks[i])) free_at(blocks[i]);
    end
    free_all_granted();
  endtask

  task automatic test_random();
    result_t r;
    int pick;
    logic [16:0] rb;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 300 && n < 450);
      if (granted_q.size() == 0 || $urandom_range(99) < 55) begin
        pick = $urandom_range(99);
        if (pick < 70)      rb = 17'($urandom_range(1, 128));
        else if (pick < 95) rb = 17'($urandom_range(129, 4096));
        else                rb = 17'($urandom_range(4097, 65536));
        alloc_bytes(rb, r);
      end else begin
        free_at(granted_q[$urandom_range(granted_q.size() - 1)]);
      end
    end
    no_idle = 1'b0;
  endtask

  // No checking on frees: repeated, misaligned and stray offsets.
  task automatic test_bad_frees();
    result_t r;
    logic [15:0] a;
    alloc_bytes(17'd24, r); a = r.paddr;
    if (freeable(a)) begin
      free_at(a);
      free_at(a);  // double free
    end
    for (int i = 0; i < 8; i++) begin
      a = 16'(granted_q.size() != 0 ? granted_q[$urandom_range(granted_q.size() - 1)] : HDR);
      a = a + 16'($urandom_range(1, 7));  // same header slot, low bits set
      if (freeable(a)) free_at(a);
    end
    for (int i = 0; i < 200; i++) begin
      a = 16'($urandom);
      if (freeable(a)) free_at(a);
    end
    for (int i = 0; i < 10; i++) alloc_bytes(17'($urandom_range(1, 65536)), r);
  endtask

  // Every strobe is one transfer; it must match the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && valid_o) begin
      if (answer_q.size() == 0) begin
        report("unexpected result", {14'd0, status_o, payload_addr_o}, 32'd0);
      end else begin
        want = answer_q.pop_front();
        if (status_o !== want.status) report("status", 32'(status_o), 32'(want.status));
        if (payload_addr_o !== want.paddr) begin
          report("payload_addr", 32'(payload_addr_o), 32'(want.paddr));
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycles, answer_q.size());
      $display("** first_fit_heap_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_exhaust();
    test_table_full();
    test_random();
    test_bad_frees();
    start_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d allocs and %0d frees, %0d answers checked", n_alloc, n_free,
             n_checked);
    $display("no-fit answers %0d, table-full answers %0d, mismatches %0d", n_nofit, n_full,
             errors);
    if (errors == 0) begin
      $display("** first_fit_heap_allocator: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator: FAILED **");
    end
    $finish;
  end

endmodule
